@@ design/prrs_pkg.sv @@
`timescale 1ns / 1ps

package prrs_pkg;

    // Fixed widths of the transfer fields.
    localparam int ENQ_FLOW_W  = 5;
    localparam int SEQ_FIELD_W = 32;

    // Defaults for the top-level parameters.
    localparam int DEF_FLOWS       = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SEQ_WIDTH   = 32;

    // One input item.
    typedef struct packed {
        logic [ENQ_FLOW_W-1:0]  enq_flow;
        logic [SEQ_FIELD_W-1:0] enq_seq;
        logic                   tx_request;
    } t_in;

    // One result item.
    typedef struct packed {
        logic                   tx_valid;
        logic [ENQ_FLOW_W-1:0]  tx_flow;
        logic [SEQ_FIELD_W-1:0] tx_seq;
        logic                   enq_dropped;
    } t_out;

    // Commands from the controller to the datapath, one per step of the clearing pass or of an item.
    typedef struct packed {
        logic clr;    // clear one flow state entry after reset
        logic latch;  // capture the accepted item
        logic ring;   // take the ready ring head
        logic enq;    // apply the enqueue
        logic srd;    // read the served flow state
        logic pop;    // pop the served flow and requeue it
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

@@ design/per_flow_round_robin_scheduler.sv @@
`timescale 1ns / 1ps

// Per-flow round-robin scheduler. Each accepted item may enqueue a sequence number into
// one flow queue and may ask to transmit from the next flow in the ready ring; each item
// gives exactly one result, shown for one cycle with o_strobe high, and the receiver must
// take it then because it cannot stall the block. An item is accepted when start is high
// and busy is low; busy then stays high until the result has been shown, so no new item
// is taken before the last one is through. That stretch is set by the single read port
// of the flow state memory, which is read once for the enqueued flow and once for the
// served flow, each read registered, followed by the registered read of the sequence
// store. After reset the block first clears the flow state memory, one flow per cycle,
// and holds busy high while it does so.
module per_flow_round_robin_scheduler
    import prrs_pkg::*;
#(
    parameter int FLOWS       = DEF_FLOWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SEQ_WIDTH   = DEF_SEQ_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of each item's steps.
    prrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // Queues, ring and result datapath.
    prrs_dp #(
        .FLOWS       (FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SEQ_WIDTH   (SEQ_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

@@ design/prrs_ram.sv @@
`timescale 1ns / 1ps

module prrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/prrs_ctrl.sv @@
`timescale 1ns / 1ps

module prrs_ctrl
    import prrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_strobe
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RING  = 7'b0000100,
        S_ENQ   = 7'b0001000,
        S_SRD   = 7'b0010000,
        S_POP   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: a clearing pass, then a fixed walk through the steps of each item.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) begin
                n_state = S_IDLE;
            end
            S_IDLE: if (start) begin
                n_state = S_RING;
            end
            S_RING:  n_state = S_ENQ;
            S_ENQ:   n_state = S_SRD;
            S_SRD:   n_state = S_POP;
            S_POP:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands follow the state directly.
    always_comb begin
        o_cmd       = '0;
        o_cmd.clr   = (r_state == S_CLEAR);
        o_cmd.latch = (r_state == S_IDLE) && start;
        o_cmd.ring  = (r_state == S_RING);
        o_cmd.enq   = (r_state == S_ENQ);
        o_cmd.srd   = (r_state == S_SRD);
        o_cmd.pop   = (r_state == S_POP);
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

endmodule

@@ design/prrs_dp.sv @@
`timescale 1ns / 1ps

module prrs_dp
    import prrs_pkg::*;
#(
    parameter int FLOWS       = DEF_FLOWS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SEQ_WIDTH   = DEF_SEQ_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_item,
    output t_sts o_sts,
    output t_out o_result
);

    localparam int FW  = $clog2(FLOWS);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW = $clog2(FLOWS + 1);
    localparam int SAW = $clog2(FLOWS * QUEUE_DEPTH);
    localparam int FSW = QW + CW;

    // Item and control registers.
    t_in            r_item;
    logic [FW-1:0]  r_ready_head;
    logic [FW-1:0]  r_ready_tail;
    logic [RCW-1:0] r_ready_count;
    logic           r_served_vld;
    logic [FW-1:0]  r_served_idx;
    logic           r_dropped;
    logic           r_pop_vld;
    logic [FW-1:0]  r_clr_idx;

    logic [FW-1:0]  n_ready_head;
    logic [FW-1:0]  n_ready_tail;
    logic [RCW-1:0] n_ready_count;

    // Memory ports.
    logic                 fs_we;
    logic [FW-1:0]        fs_waddr;
    logic [FSW-1:0]       fs_wdata;
    logic [FW-1:0]        fs_raddr;
    logic [FSW-1:0]       fs_q;
    logic                 sq_we;
    logic [SAW-1:0]       sq_addr;
    logic [SEQ_WIDTH-1:0] sq_q;
    logic                 rg_we;
    logic [FW-1:0]        rg_wdata;
    logic [FW-1:0]        rg_q;

    // Decoded item and flow state fields.
    logic          enq_ok;
    logic [FW-1:0] enq_idx;
    logic [QW-1:0] fs_head;
    logic [CW-1:0] fs_count;
    logic          fs_full;
    logic          take;
    logic          enq_write;
    logic          pop_write;
    logic          append;
    logic [QW:0]   pos_sum;
    logic [QW-1:0] wr_pos;
    logic [QW-1:0] head_inc;
    logic [FW-1:0] sel_flow;
    logic [QW-1:0] sel_pos;

    assign enq_ok   = (r_item.enq_flow != '0) && (int'(r_item.enq_flow) <= FLOWS);
    assign enq_idx  = FW'(r_item.enq_flow - ENQ_FLOW_W'(1));
    assign fs_head  = fs_q[FSW-1:CW];
    assign fs_count = fs_q[CW-1:0];
    assign fs_full  = (fs_count == CW'(QUEUE_DEPTH));
    assign take     = r_item.tx_request && (r_ready_count != '0);

    // Tail slot of the enqueued flow; head and count stay below the depth here.
    assign pos_sum  = {1'b0, fs_head} + (QW+1)'(fs_count);
    assign wr_pos   = (pos_sum >= (QW+1)'(QUEUE_DEPTH))
                    ? QW'(pos_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(pos_sum);
    assign head_inc = (fs_head == QW'(QUEUE_DEPTH - 1)) ? '0 : fs_head + QW'(1);

    // Writes happen in different steps, so enq and pop never overlap.
    assign enq_write = i_cmd.enq && enq_ok && !fs_full;
    assign pop_write = i_cmd.pop && r_served_vld && (fs_count != '0);

    // A newly non-empty flow is appended first, the served flow afterwards.
    always_comb begin
        append   = 1'b0;
        rg_wdata = r_served_idx;
        if (i_cmd.enq) begin
            append   = enq_write && (fs_count == '0)
                    && !(r_served_vld && (r_served_idx == enq_idx));
            rg_wdata = enq_idx;
        end else if (i_cmd.pop) begin
            append = pop_write && (fs_count > CW'(1));
        end
        if (r_ready_count >= RCW'(FLOWS)) begin
            append = 1'b0;
        end
    end
    assign rg_we = append;

    // Flow state memory port control.
    always_comb begin
        fs_we    = i_cmd.clr || enq_write || pop_write;
        fs_waddr = enq_idx;
        fs_wdata = {fs_head, CW'(fs_count + CW'(1))};
        if (i_cmd.clr) begin
            fs_waddr = r_clr_idx;
            fs_wdata = '0;
        end else if (i_cmd.pop) begin
            fs_waddr = r_served_idx;
            fs_wdata = {head_inc, CW'(fs_count - CW'(1))};
        end
    end
    assign fs_raddr = i_cmd.srd ? r_served_idx : enq_idx;

    // One address path into the sequence store, shared by the write and the pop read.
    assign sel_flow = i_cmd.pop ? r_served_idx : enq_idx;
    assign sel_pos  = i_cmd.pop ? fs_head : wr_pos;
    assign sq_addr  = SAW'(SAW'(sel_flow) * SAW'(QUEUE_DEPTH) + SAW'(sel_pos));
    assign sq_we    = enq_write;

    // Ring pointers and occupancy.
    always_comb begin
        n_ready_head  = r_ready_head;
        n_ready_tail  = r_ready_tail;
        n_ready_count = r_ready_count;
        if (i_cmd.ring && take) begin
            n_ready_head  = (r_ready_head == FW'(FLOWS - 1)) ? '0 : r_ready_head + FW'(1);
            n_ready_count = r_ready_count - RCW'(1);
        end
        if (append) begin
            n_ready_tail  = (r_ready_tail == FW'(FLOWS - 1)) ? '0 : r_ready_tail + FW'(1);
            n_ready_count = r_ready_count + RCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_head  <= '0;
            r_ready_tail  <= '0;
            r_ready_count <= '0;
            r_served_vld  <= 1'b0;
            r_dropped     <= 1'b0;
            r_pop_vld     <= 1'b0;
            r_clr_idx     <= '0;
        end else begin
            r_ready_head  <= n_ready_head;
            r_ready_tail  <= n_ready_tail;
            r_ready_count <= n_ready_count;
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + FW'(1);
            end
            if (i_cmd.ring) begin
                r_served_vld <= take;
            end
            if (i_cmd.enq) begin
                r_dropped <= enq_ok && fs_full;
            end
            if (i_cmd.pop) begin
                r_pop_vld <= pop_write;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.ring) begin
            r_served_idx <= rg_q;
        end
    end

    prrs_ram #(.WIDTH(FSW), .DEPTH(FLOWS)) u_flow_state (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_q)
    );

    prrs_ram #(.WIDTH(SEQ_WIDTH), .DEPTH(FLOWS * QUEUE_DEPTH)) u_seq_store (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_addr),
        .i_wdata (SEQ_WIDTH'(r_item.enq_seq)),
        .i_raddr (sq_addr),
        .o_rdata (sq_q)
    );

    prrs_ram #(.WIDTH(FW), .DEPTH(FLOWS)) u_ready_ring (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (r_ready_tail),
        .i_wdata (rg_wdata),
        .i_raddr (r_ready_head),
        .o_rdata (rg_q)
    );

    assign o_sts.clr_last = (r_clr_idx == FW'(FLOWS - 1));

    // Result fields; the popped sequence number arrives from the store in the output step.
    always_comb begin
        o_result             = '0;
        o_result.tx_valid    = r_served_vld;
        o_result.tx_flow     = r_served_vld
                             ? ENQ_FLOW_W'({1'b0, r_served_idx} + (FW+1)'(1)) : '0;
        o_result.tx_seq      = r_pop_vld ? SEQ_FIELD_W'(sq_q) : '0;
        o_result.enq_dropped = r_dropped;
    end

endmodule

@@ design/prrs_checker.sv @@
`timescale 1ns / 1ps

module prrs_checker
    import prrs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    // A result is only shown while an item is in work.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside an item");

    // An accepted transfer makes the block busy at once.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a transfer");

    // Exactly one result per item: no second strobe back to back.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("more than one result for an item");

    // A result without service carries no flow and no sequence number.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.tx_valid) |->
        (o_result.tx_flow == '0) && (o_result.tx_seq == '0))
        else $error("fields set on a result without service");

    // A served flow is always numbered from one.
    a_flow_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.tx_valid) |-> (o_result.tx_flow != '0))
        else $error("served flow numbered zero");

endmodule

bind per_flow_round_robin_scheduler prrs_checker u_prrs_checker (.*);
